### src/befs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// befs_pkg: shared types and constants of the brace entry field splitter
// Character codes, result kinds, beat payloads and the command and status
// structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package befs_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    KIND_LABEL = 3'd0,
    KIND_ITEM  = 3'd1,
    KIND_REST  = 3'd2,
    KIND_OK    = 3'd3,
    KIND_ERR   = 3'd4,
    KIND_TRUNC = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    SEL_CHAR,
    SEL_STATUS,
    SEL_REPLAY
  } sel_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_entry;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_char;
    logic       last;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd;
    logic emit;
    sel_e sel;
    logic last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic plan_rpl;
    logic plan_chr;
    logic plan_sts;
    logic rpl_last;
  } dp_status_t;

  // Space, tab, line feed, vertical tab, form feed and carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

### src/befs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// befs_stream_if: valid/ready channel
// Carries one beat of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface befs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/befs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// befs_datapath: entry state, label memory and output register
// Works out the results of one character, stores label characters and
// drives the output beat register under the controller's commands.
// ----------------------------------------------------------------------------
module befs_datapath #(
  parameter int LABEL_DEPTH = 32,
  parameter int PREFIX_LEN  = 7,
  parameter int BRACE_MAX   = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  befs_pkg::in_beat_t   in_beat_i,
  input  befs_pkg::dp_cmd_t    cmd_i,
  input  logic                 out_ready_i,
  output befs_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  output befs_pkg::out_beat_t  out_beat_o
);
  import befs_pkg::*;

  localparam int IDX_W   = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam int LEN_W   = $clog2(LABEL_DEPTH + 1);
  localparam int PCNT_W  = (PREFIX_LEN > 0) ? $clog2(PREFIX_LEN + 1) : 1;
  localparam int DEPTH_W = $clog2(BRACE_MAX + 1);

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_LABEL,
    PH_WS,
    PH_ITEM,
    PH_REST
  } phase_e;

  typedef struct packed {
    logic             rpl;
    logic [LEN_W-1:0] len;
    logic             chr;
    kind_e            ch_kind;
    logic [7:0]       ch;
    logic             sts;
    kind_e            sts_kind;
  } plan_t;

  phase_e             phase_q, phase_d;
  logic [PCNT_W-1:0]  pcnt_q, pcnt_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [7:0]         prev_q, prev_d;
  logic [LEN_W-1:0]   llen_q, llen_d;
  logic               seen_q, seen_d;
  logic               trunc_q, trunc_d;
  logic [IDX_W-1:0]   rpl_idx_q;

  logic [7:0]         label_mem [LABEL_DEPTH];
  logic [7:0]         rd_data_q;

  plan_t              plan_live, plan_q, plan_src;
  logic               wr_en;
  logic               out_valid_q;
  out_beat_t          out_q;
  logic               out_free;

  always_comb begin
    logic [7:0] c;
    logic       plain;
    logic       do_item;
    logic       do_label;
    logic       rpl_raw;

    c        = in_beat_i.ch;
    plain    = (prev_q != CH_BSLASH);
    do_item  = 1'b0;
    do_label = 1'b0;
    rpl_raw  = 1'b0;
    wr_en    = 1'b0;
    phase_d  = phase_q;
    pcnt_d   = pcnt_q;
    depth_d  = depth_q;
    prev_d   = c;
    llen_d   = llen_q;
    seen_d   = seen_q;
    trunc_d  = trunc_q;
    plan_live          = '0;
    plan_live.ch       = c;
    plan_live.ch_kind  = KIND_LABEL;
    plan_live.sts_kind = KIND_ERR;

    if (phase_q == PH_PREFIX) begin
      if (pcnt_q < PCNT_W'(PREFIX_LEN)) begin
        pcnt_d = pcnt_q + 1'b1;
      end else begin
        phase_d = PH_LABEL;
      end
    end

    case (phase_d)
      PH_PREFIX: begin
      end
      PH_LABEL: begin
        if (c == CH_LBRACE && plain) begin
          if (depth_d < DEPTH_W'(BRACE_MAX)) depth_d = depth_d + 1'b1;
          do_label = 1'b1;
        end else if (c == CH_RBRACE) begin
          if (plain && depth_d != '0) depth_d = depth_d - 1'b1;
          if (depth_d == '0) phase_d = PH_WS;
          else do_label = 1'b1;
        end else if (c == CH_COMMA) begin
          phase_d = PH_WS;
        end else begin
          do_label = 1'b1;
        end
      end
      PH_WS: begin
        if (!is_ws(c)) begin
          if (depth_d == '0) begin
            rpl_raw           = 1'b1;
            phase_d           = PH_REST;
            plan_live.chr     = 1'b1;
            plan_live.ch_kind = KIND_REST;
          end else begin
            phase_d = PH_ITEM;
            do_item = 1'b1;
          end
        end
      end
      PH_ITEM: do_item = 1'b1;
      PH_REST: begin
        plan_live.chr     = 1'b1;
        plan_live.ch_kind = KIND_REST;
      end
      default: begin
      end
    endcase

    if (do_label) begin
      plan_live.chr     = 1'b1;
      plan_live.ch_kind = KIND_LABEL;
      if (llen_q < LEN_W'(LABEL_DEPTH)) begin
        wr_en  = 1'b1;
        llen_d = llen_q + 1'b1;
      end else begin
        trunc_d = 1'b1;
      end
    end

    if (do_item) begin
      if (c == CH_LBRACE && plain) begin
        if (depth_d < DEPTH_W'(BRACE_MAX)) depth_d = depth_d + 1'b1;
        plan_live.chr     = 1'b1;
        plan_live.ch_kind = KIND_ITEM;
        seen_d            = 1'b1;
      end else if (c == CH_RBRACE && plain) begin
        if (depth_d != '0) depth_d = depth_d - 1'b1;
        if (depth_d == '0) begin
          // Closing brace of an empty item: the label stands in for it.
          rpl_raw = !seen_q;
          phase_d = PH_REST;
        end else begin
          plan_live.chr     = 1'b1;
          plan_live.ch_kind = KIND_ITEM;
          seen_d            = 1'b1;
        end
      end else begin
        plan_live.chr     = 1'b1;
        plan_live.ch_kind = KIND_ITEM;
        seen_d            = 1'b1;
      end
    end

    plan_live.len = llen_d;

    if (in_beat_i.end_of_entry) begin
      plan_live.sts = 1'b1;
      if (phase_d == PH_REST) begin
        plan_live.sts_kind = trunc_d ? KIND_TRUNC : KIND_OK;
      end else if (phase_d == PH_WS && depth_d == '0) begin
        rpl_raw            = 1'b1;
        plan_live.sts_kind = trunc_d ? KIND_TRUNC : KIND_OK;
      end else begin
        plan_live.sts_kind = KIND_ERR;
      end
      phase_d = PH_PREFIX;
      pcnt_d  = '0;
      depth_d = DEPTH_W'(1);
      prev_d  = '0;
      llen_d  = '0;
      seen_d  = 1'b0;
      trunc_d = 1'b0;
    end

    plan_live.rpl = rpl_raw && (plan_live.len != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PREFIX;
      pcnt_q    <= '0;
      depth_q   <= DEPTH_W'(1);
      prev_q    <= '0;
      llen_q    <= '0;
      seen_q    <= 1'b0;
      trunc_q   <= 1'b0;
      rpl_idx_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        phase_q   <= phase_d;
        pcnt_q    <= pcnt_d;
        depth_q   <= depth_d;
        prev_q    <= prev_d;
        llen_q    <= llen_d;
        seen_q    <= seen_d;
        trunc_q   <= trunc_d;
        rpl_idx_q <= '0;
      end else if (cmd_i.emit && cmd_i.sel == SEL_REPLAY) begin
        rpl_idx_q <= rpl_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) plan_q <= plan_live;
  end

  // Label memory: written at the current label length, read for replay.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) label_mem[llen_q[IDX_W-1:0]] <= in_beat_i.ch;
    if (cmd_i.rd) rd_data_q <= label_mem[rpl_idx_q];
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign plan_src = cmd_i.accept ? plan_live : plan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cmd_i.emit) begin
      out_q.last <= cmd_i.last;
      case (cmd_i.sel)
        SEL_CHAR: begin
          out_q.kind     <= plan_src.ch_kind;
          out_q.out_char <= plan_src.ch;
        end
        SEL_STATUS: begin
          out_q.kind     <= plan_src.sts_kind;
          out_q.out_char <= '0;
        end
        SEL_REPLAY: begin
          out_q.kind     <= KIND_ITEM;
          out_q.out_char <= rd_data_q;
        end
        default: begin
          out_q.kind     <= KIND_ERR;
          out_q.out_char <= '0;
        end
      endcase
    end
  end

  assign status_o.out_free = out_free;
  assign status_o.plan_rpl = plan_live.rpl;
  assign status_o.plan_chr = plan_live.chr;
  assign status_o.plan_sts = plan_live.sts;
  assign status_o.rpl_last = ((LEN_W'(rpl_idx_q) + LEN_W'(1)) == plan_q.len);

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

### src/befs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// befs_ctrl: sequencing controller
// Accepts characters and orders the result beats of each one: label
// replay first, then the character, then the entry status.
// ----------------------------------------------------------------------------
module befs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  befs_pkg::dp_status_t status_i,
  output befs_pkg::dp_cmd_t    cmd_o
);
  import befs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_REPLAY,
    ST_CHAR,
    ST_STATUS
  } state_e;

  state_e state_q, state_d;
  logic   chr_pend_q, chr_pend_d;
  logic   sts_pend_q, sts_pend_d;

  always_comb begin
    state_d    = state_q;
    chr_pend_d = chr_pend_q;
    sts_pend_d = sts_pend_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_CHAR;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.accept = 1'b1;
          chr_pend_d   = status_i.plan_chr;
          sts_pend_d   = status_i.plan_sts;
          if (status_i.plan_rpl) begin
            state_d = ST_READ;
          end else if (status_i.plan_chr) begin
            cmd_o.emit = 1'b1;
            cmd_o.sel  = SEL_CHAR;
            cmd_o.last = !status_i.plan_sts;
            if (status_i.plan_sts) state_d = ST_STATUS;
          end else if (status_i.plan_sts) begin
            cmd_o.emit = 1'b1;
            cmd_o.sel  = SEL_STATUS;
            cmd_o.last = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_REPLAY;
      end
      ST_REPLAY: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_REPLAY;
          cmd_o.last = status_i.rpl_last && !chr_pend_q && !sts_pend_q;
          if (!status_i.rpl_last) state_d = ST_READ;
          else if (chr_pend_q) state_d = ST_CHAR;
          else if (sts_pend_q) state_d = ST_STATUS;
          else state_d = ST_IDLE;
        end
      end
      ST_CHAR: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_CHAR;
          cmd_o.last = !sts_pend_q;
          state_d    = sts_pend_q ? ST_STATUS : ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_STATUS;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      chr_pend_q <= 1'b0;
      sts_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      chr_pend_q <= chr_pend_d;
      sts_pend_q <= sts_pend_d;
    end
  end

endmodule

### src/brace_entry_field_splitter.sv
`timescale 1ns / 1ps
// A single result beat is loaded as its character is taken and shows the cycle after.
// Throughput: one character per cycle, given at most one result beat and a free output.
// A label replay reads each stored character from the label memory, then loads it into
// the output register; a status beat after a character is loaded after that character.
// Reset is asynchronous and active low; the label memory is not cleared, as only
// entries below the current label length are ever read.
// ----------------------------------------------------------------------------
// brace_entry_field_splitter: splits entry text into label, item and remainder
// Drops the fixed prefix, tracks brace depth with backslash escapes and
// reports an end-of-entry status for each entry.
// ----------------------------------------------------------------------------
module brace_entry_field_splitter #(
  parameter int LABEL_DEPTH = 32,
  parameter int PREFIX_LEN  = 7,
  parameter int BRACE_MAX   = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  befs_stream_if.sink   in_i,
  befs_stream_if.source out_o
);
  import befs_pkg::*;

  // The controller and the datapath talk only through these two structures.
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_beat_t  out_beat;

  // The controller decides when a character beat is taken and which result
  // goes into the output register on each cycle. A character that gives one
  // result is taken and its result loaded in the same cycle, so plain text
  // streams at one character per cycle while the output keeps moving.
  befs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the entry state (phase, prefix count, brace depth,
  // previous character, label length and flags), the label memory and the
  // output register, which parts the input side from a stalled consumer.
  befs_datapath #(
    .LABEL_DEPTH (LABEL_DEPTH),
    .PREFIX_LEN  (PREFIX_LEN),
    .BRACE_MAX   (BRACE_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_i.payload),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_beat_o  (out_beat)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_beat;

  // A new result is only loaded when the output register is free to take it.
  a_emit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result loaded while the output register was still occupied");

  // A label memory read never coincides with taking a new character.
  a_read_not_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd && cmd.accept))
    else $error("label read issued in the same cycle as a character accept");

  // A status beat always closes the results of its character.
  a_status_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload.kind < KIND_OK || out_o.payload.last))
    else $error("status beat without the last flag");

endmodule
